// File: hw/rtl/dsa_pkg.sv
// Shared types and constants for the duration statistics accumulator.
package dsa_pkg;

  // Default parameter values
  localparam int unsigned SEC_BITS_DEF   = 32;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Fixed field widths of the item and result ports
  localparam int unsigned FIELD_SEC_W  = 32;
  localparam int unsigned FIELD_USEC_W = 20;

  // Microsecond constants
  localparam logic [FIELD_USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [FIELD_USEC_W-1:0] USEC_MAX     = 20'd999999;

  // Mode codes on the input port
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  typedef enum logic {
    OP_ADD,
    OP_REPORT
  } op_e;

  // One classified item between front and back
  typedef struct packed {
    op_e                     op;
    logic [FIELD_SEC_W-1:0]  sec;
    logic [FIELD_USEC_W-1:0] usec;
  } item_t;

  // One report item
  typedef struct packed {
    logic [FIELD_SEC_W-1:0]  mean_sec;
    logic [FIELD_USEC_W-1:0] mean_usec;
    logic [FIELD_SEC_W-1:0]  least_sec;
    logic [FIELD_USEC_W-1:0] least_usec;
    logic [FIELD_SEC_W-1:0]  most_sec;
    logic [FIELD_USEC_W-1:0] most_usec;
    logic [FIELD_SEC_W-1:0]  sample_count;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_SEC,
    BK_SCALE,
    BK_FOLD,
    BK_DIV_USEC,
    BK_DONE
  } back_state_e;

endpackage

// File: hw/rtl/dsa_front.sv
// Front stage: takes input items, decodes the mode and cleans the sample fields.
module dsa_front import dsa_pkg::*; #(
  parameter int unsigned SEC_BITS = SEC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [FIELD_SEC_W-1:0]  sample_sec_i,
  input  logic [FIELD_USEC_W-1:0] sample_usec_i,
  output logic                    item_valid_o,
  input  logic                    item_ready_i,
  output item_t                   item_o
);

  // Seconds bits at and above SEC_BITS are dropped
  localparam logic [FIELD_SEC_W-1:0] SecMask = (SEC_BITS >= FIELD_SEC_W) ? '1 :
      FIELD_SEC_W'((64'(1) << SEC_BITS) - 64'(1));

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_ready_o = !valid_q || item_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Decode and clamp
  always_comb begin
    item_d = item_q;
    if (load) begin
      unique case (mode_i)
        MODE_ADD:    item_d.op = OP_ADD;
        MODE_REPORT: item_d.op = OP_REPORT;
      endcase
      item_d.sec  = sample_sec_i & SecMask;
      item_d.usec = (sample_usec_i >= USEC_PER_SEC) ? USEC_MAX : sample_usec_i;
    end
  end

  assign valid_d = load ? 1'b1 : (valid_q && !item_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// File: hw/rtl/dsa_fifo.sv
// Short item queue between the front and back stages.
module dsa_fifo import dsa_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: hw/rtl/dsa_div.sv
// Restoring divider, one quotient bit per cycle.
module dsa_div #(
  parameter int unsigned DIV_W = 52,
  parameter int unsigned DVS_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o,
  output logic [DVS_W-1:0] remainder_o
);

  localparam int unsigned CntW = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DIV_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], fits};
      rem_d = fits ? DVS_W'(trial - {1'b0, divisor_i}) : trial[DVS_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: hw/rtl/dsa_back.sv
// Back stage: statistics state, sample update and the report sequencer.
module dsa_back import dsa_pkg::*; #(
  parameter int unsigned SEC_BITS   = SEC_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int unsigned SmpW = (SEC_BITS < FIELD_SEC_W) ? SEC_BITS : FIELD_SEC_W;
  localparam int unsigned SumW = SEC_BITS + 16;
  localparam int unsigned MulW = COUNT_BITS + FIELD_USEC_W;
  localparam int unsigned DivW = (SumW > MulW) ? SumW : MulW;
  localparam int unsigned UW   = FIELD_USEC_W;
  localparam logic [SumW:0] SecMax = {{(SumW + 1 - SEC_BITS){1'b0}}, {SEC_BITS{1'b1}}};

  back_state_e state_q, state_d;

  logic [SmpW-1:0]       min_sec_q, min_sec_d;
  logic [UW-1:0]         min_usec_q, min_usec_d;
  logic [SmpW-1:0]       max_sec_q, max_sec_d;
  logic [UW-1:0]         max_usec_q, max_usec_d;
  logic [SumW-1:0]       sum_sec_q, sum_sec_d;
  logic [UW-1:0]         sum_usec_q, sum_usec_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  logic [SumW-1:0]       qsec_q, qsec_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [MulW-1:0]       scale_q, scale_d;
  logic [4:0]            step_q, step_d;
  logic [SEC_BITS-1:0]   mean_sec_q, mean_sec_d;
  logic [UW-1:0]         mean_usec_q, mean_usec_d;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;

  logic                  div_start, div_busy, div_done;
  logic [DivW-1:0]       div_dividend, div_quo;
  logic [COUNT_BITS-1:0] div_rem;

  // Sample update datapath
  logic [SmpW-1:0]       smp_sec;
  logic [UW:0]           usec_sum;
  logic                  usec_carry;
  logic [UW-1:0]         usec_next;
  logic [SumW:0]         sec_sum;
  logic [SumW-1:0]       sec_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  above_max, below_min;

  assign smp_sec    = item_i.sec[SmpW-1:0];
  assign usec_sum   = (UW+1)'(sum_usec_q) + (UW+1)'(item_i.usec);
  assign usec_carry = (usec_sum >= (UW+1)'(USEC_PER_SEC));
  assign usec_next  = usec_carry ? UW'(usec_sum - (UW+1)'(USEC_PER_SEC)) : usec_sum[UW-1:0];
  assign sec_sum    = (SumW+1)'(sum_sec_q) + (SumW+1)'(smp_sec) + (SumW+1)'(usec_carry);
  assign sec_next   = sec_sum[SumW] ? '1 : sec_sum[SumW-1:0];
  assign count_next = (&count_q) ? count_q : count_q + COUNT_BITS'(1);
  assign above_max  = ({max_sec_q, max_usec_q} < {smp_sec, item_i.usec});
  assign below_min  = ({smp_sec, item_i.usec} < {min_sec_q, min_usec_q});

  // Mean fold and saturation after the second division
  logic [UW:0]   frac;
  logic          frac_carry;
  logic [SumW:0] mean_wide;
  logic [UW-1:0] frac_norm;

  assign frac       = div_quo[UW:0];
  assign frac_carry = (frac >= (UW+1)'(USEC_PER_SEC));
  assign mean_wide  = (SumW+1)'(qsec_q) + (SumW+1)'(frac_carry);
  assign frac_norm  = frac_carry ? UW'(frac - (UW+1)'(USEC_PER_SEC)) : frac[UW-1:0];

  dsa_div #(
    .DIV_W (DivW),
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (count_q),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state and sequencer outputs
  always_comb begin
    state_d      = state_q;
    min_sec_d    = min_sec_q;
    min_usec_d   = min_usec_q;
    max_sec_d    = max_sec_q;
    max_usec_d   = max_usec_q;
    sum_sec_d    = sum_sec_q;
    sum_usec_d   = sum_usec_q;
    count_d      = count_q;
    qsec_d       = qsec_q;
    rem_d        = rem_q;
    scale_d      = scale_q;
    step_d       = step_q;
    mean_sec_d   = mean_sec_q;
    mean_usec_d  = mean_usec_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !res_ready_i;
    item_ready_o = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;

    unique case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          item_ready_o = 1'b1;
          unique case (item_i.op)
            OP_ADD: begin
              // first sample sets both extremes
              if (count_q == '0 || above_max) begin
                max_sec_d  = smp_sec;
                max_usec_d = item_i.usec;
              end
              if (count_q == '0 || below_min) begin
                min_sec_d  = smp_sec;
                min_usec_d = item_i.usec;
              end
              sum_usec_d = usec_next;
              sum_sec_d  = sec_next;
              count_d    = count_next;
            end
            OP_REPORT: begin
              if (count_q == '0) begin
                mean_sec_d  = '0;
                mean_usec_d = '0;
                state_d     = BK_DONE;
              end else begin
                div_start    = 1'b1;
                div_dividend = DivW'(sum_sec_q);
                state_d      = BK_DIV_SEC;
              end
            end
          endcase
        end
      end
      BK_DIV_SEC: begin
        if (div_done) begin
          qsec_d  = div_quo[SumW-1:0];
          rem_d   = div_rem;
          scale_d = '0;
          step_d  = 5'd19;
          state_d = BK_SCALE;
        end
      end
      BK_SCALE: begin
        // remainder times one million, one constant bit per cycle
        scale_d = {scale_q[MulW-2:0], 1'b0} + (USEC_PER_SEC[step_q] ? MulW'(rem_q) : '0);
        if (step_q == '0) begin
          state_d = BK_FOLD;
        end else begin
          step_d = step_q - 5'd1;
        end
      end
      BK_FOLD: begin
        div_start    = 1'b1;
        div_dividend = DivW'(scale_q + MulW'(sum_usec_q));
        state_d      = BK_DIV_USEC;
      end
      BK_DIV_USEC: begin
        if (div_done) begin
          if (mean_wide > SecMax) begin
            mean_sec_d  = '1;
            mean_usec_d = USEC_MAX;
          end else begin
            mean_sec_d  = mean_wide[SEC_BITS-1:0];
            mean_usec_d = frac_norm;
          end
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          res_d.mean_sec     = FIELD_SEC_W'(mean_sec_q);
          res_d.mean_usec    = mean_usec_q;
          res_d.least_sec    = FIELD_SEC_W'(min_sec_q);
          res_d.least_usec   = min_usec_q;
          res_d.most_sec     = FIELD_SEC_W'(max_sec_q);
          res_d.most_usec    = max_usec_q;
          res_d.sample_count = FIELD_SEC_W'(count_q);
          out_valid_d        = 1'b1;
          state_d            = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      min_sec_q   <= '0;
      min_usec_q  <= '0;
      max_sec_q   <= '0;
      max_usec_q  <= '0;
      sum_sec_q   <= '0;
      sum_usec_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_sec_q   <= min_sec_d;
      min_usec_q  <= min_usec_d;
      max_sec_q   <= max_sec_d;
      max_usec_q  <= max_usec_d;
      sum_sec_q   <= sum_sec_d;
      sum_usec_q  <= sum_usec_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Report working registers and result holding register
  always_ff @(posedge clk_i) begin
    qsec_q      <= qsec_d;
    rem_q       <= rem_d;
    scale_q     <= scale_d;
    step_q      <= step_d;
    mean_sec_q  <= mean_sec_d;
    mean_usec_q <= mean_usec_d;
    res_q       <= res_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_sum_usec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_usec_q < USEC_PER_SEC)
    else $error("running microsecond total out of range");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q >= $past(count_q))
    else $error("sample count went backwards");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == BK_DIV_SEC || state_q == BK_DIV_USEC))
    else $error("divider busy outside a division state");

  a_mean_usec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_q.mean_usec < USEC_PER_SEC)
    else $error("reported mean microseconds out of range");
`endif

endmodule

// File: hw/rtl/duration_statistics_accumulator_core.sv
// Latency: an item passes a front register and the queue before the back stage sees it.
// Add items: one per cycle while no report is in progress; each updates the state.
// Report items: the back stage runs the one-bit-per-cycle DW-bit divider twice, with a
//   20-step scaling loop between, unless empty; DW = max(SEC_BITS+16, COUNT_BITS+20).
// Reset (rst_ni low, asynchronous): minimum, maximum, total and count clear to zero,
//   queue and result register empty; no clearing pass is needed.
module duration_statistics_accumulator_core import dsa_pkg::*; #(
  parameter int unsigned SEC_BITS   = SEC_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    mode_i,
  input  logic [FIELD_SEC_W-1:0]  sample_sec_i,
  input  logic [FIELD_USEC_W-1:0] sample_usec_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [FIELD_SEC_W-1:0]  mean_sec_o,
  output logic [FIELD_USEC_W-1:0] mean_usec_o,
  output logic [FIELD_SEC_W-1:0]  least_sec_o,
  output logic [FIELD_USEC_W-1:0] least_usec_o,
  output logic [FIELD_SEC_W-1:0]  most_sec_o,
  output logic [FIELD_USEC_W-1:0] most_usec_o,
  output logic [FIELD_SEC_W-1:0]  sample_count_o
);

  logic    fr_valid, fr_ready;
  item_t   fr_item;
  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  // Front: decode and clean
  dsa_front #(
    .SEC_BITS (SEC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .sample_sec_i  (sample_sec_i),
    .sample_usec_i (sample_usec_i),
    .item_valid_o  (fr_valid),
    .item_ready_i  (fr_ready),
    .item_o        (fr_item)
  );

  // Decoupling queue
  dsa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // Back: statistics and reports
  dsa_back #(
    .SEC_BITS   (SEC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign mean_sec_o     = res.mean_sec;
  assign mean_usec_o    = res.mean_usec;
  assign least_sec_o    = res.least_sec;
  assign least_usec_o   = res.least_usec;
  assign most_sec_o     = res.most_sec;
  assign most_usec_o    = res.most_usec;
  assign sample_count_o = res.sample_count;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the duration statistics accumulator core.
module testbench;
  import dsa_pkg::*;

  localparam int unsigned TOTAL_SEC_W = SEC_BITS_DEF + 16;
  localparam logic [TOTAL_SEC_W-1:0] TOTAL_SEC_MAX = '1;
  localparam logic [FIELD_SEC_W-1:0] COUNT_MAX = '1;
  localparam logic [FIELD_SEC_W-1:0] SEC_MAX = '1;
  localparam int unsigned RANDOM_ITEMS = 890;
  localparam int unsigned MAX_RUN_ADDS = 40;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    mode_i = MODE_ADD;
  logic [FIELD_SEC_W-1:0]  sample_sec_i = '0;
  logic [FIELD_USEC_W-1:0] sample_usec_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [FIELD_SEC_W-1:0]  mean_sec_o;
  logic [FIELD_USEC_W-1:0] mean_usec_o;
  logic [FIELD_SEC_W-1:0]  least_sec_o;
  logic [FIELD_USEC_W-1:0] least_usec_o;
  logic [FIELD_SEC_W-1:0]  most_sec_o;
  logic [FIELD_USEC_W-1:0] most_usec_o;
  logic [FIELD_SEC_W-1:0]  sample_count_o;

  duration_statistics_accumulator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .sample_sec_i   (sample_sec_i),
    .sample_usec_i  (sample_usec_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_sec_o     (mean_sec_o),
    .mean_usec_o    (mean_usec_o),
    .least_sec_o    (least_sec_o),
    .least_usec_o   (least_usec_o),
    .most_sec_o     (most_sec_o),
    .most_usec_o    (most_usec_o),
    .sample_count_o (sample_count_o)
  );

  // Shadow copy of the accumulator state
  logic [FIELD_SEC_W-1:0]  acc_min_sec;
  logic [FIELD_USEC_W-1:0] acc_min_usec;
  logic [FIELD_SEC_W-1:0]  acc_max_sec;
  logic [FIELD_USEC_W-1:0] acc_max_usec;
  logic [TOTAL_SEC_W-1:0]  acc_total_sec;
  logic [FIELD_USEC_W-1:0] acc_total_usec;
  logic [FIELD_SEC_W-1:0]  acc_count;

  result_t pending_reports[$];

  // Traffic shaping knobs
  bit          quiet = 1'b0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;

  int unsigned    error_count = 0;
  int unsigned    add_count = 0;
  int unsigned    report_count = 0;
  int unsigned    checked_count = 0;
  longint unsigned cycle_count = 0;

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
               pending_reports.size());
      $display("duration_statistics_accumulator_core test failed");
      $finish;
    end
  end

  // Fold one sample into the shadow state
  task automatic fold_sample(logic [FIELD_SEC_W-1:0] s, logic [FIELD_USEC_W-1:0] u_raw);
    logic [FIELD_USEC_W-1:0] u;
    logic [FIELD_USEC_W:0]   usec_sum;
    logic                    carry;
    u = (u_raw > USEC_MAX) ? USEC_MAX : u_raw;
    if (acc_count == '0) begin
      acc_min_sec = s;
      acc_min_usec = u;
      acc_max_sec = s;
      acc_max_usec = u;
    end else begin
      // usec is a fixed-width low field, so the concatenation orders lexically
      if ({s, u} > {acc_max_sec, acc_max_usec}) begin
        acc_max_sec = s;
        acc_max_usec = u;
      end
      if ({s, u} < {acc_min_sec, acc_min_usec}) begin
        acc_min_sec = s;
        acc_min_usec = u;
      end
    end
    usec_sum = {1'b0, acc_total_usec} + {1'b0, u};
    carry = (usec_sum >= {1'b0, USEC_PER_SEC});
    if (carry) usec_sum = usec_sum - {1'b0, USEC_PER_SEC};
    acc_total_usec = usec_sum[FIELD_USEC_W-1:0];
    // Saturating seconds total
    if ({16'd0, s} > TOTAL_SEC_MAX - acc_total_sec) begin
      acc_total_sec = TOTAL_SEC_MAX;
    end else begin
      acc_total_sec = acc_total_sec + {16'd0, s};
      if (carry && acc_total_sec != TOTAL_SEC_MAX)
        acc_total_sec = acc_total_sec + TOTAL_SEC_W'(1);
    end
    if (acc_count != COUNT_MAX) acc_count = acc_count + FIELD_SEC_W'(1);
  endtask

  // Statistics the block should report for the current shadow state
  function automatic result_t stats_snapshot();
    result_t     r;
    logic [63:0] cnt;
    logic [63:0] tot;
    logic [63:0] whole;
    logic [63:0] part;
    r = '0;
    if (acc_count != '0) begin
      cnt = {32'd0, acc_count};
      tot = {16'd0, acc_total_sec};
      whole = tot / cnt;
      part = ((tot % cnt) * 64'd1000000 + {44'd0, acc_total_usec}) / cnt;
      if (part >= 64'(USEC_PER_SEC)) begin
        whole = whole + 64'd1;
        part = part - 64'(USEC_PER_SEC);
      end
      if (whole > {32'd0, SEC_MAX}) begin
        whole = {32'd0, SEC_MAX};
        part = 64'(USEC_MAX);
      end
      r.mean_sec = whole[FIELD_SEC_W-1:0];
      r.mean_usec = part[FIELD_USEC_W-1:0];
    end
    r.least_sec = acc_min_sec;
    r.least_usec = acc_min_usec;
    r.most_sec = acc_max_sec;
    r.most_usec = acc_max_usec;
    r.sample_count = acc_count;
    return r;
  endfunction

  // Send one item; called and returning at a rising edge
  task automatic send_item(op_e op, logic [FIELD_SEC_W-1:0] s, logic [FIELD_USEC_W-1:0] u);
    if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= (op == OP_REPORT) ? MODE_REPORT : MODE_ADD;
    sample_sec_i <= s;
    sample_usec_i <= u;
    // ready sampled mid-cycle, handshake lands on the following edge
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    if (op == OP_REPORT) begin
      pending_reports.push_back(stats_snapshot());
      report_count++;
    end else begin
      fold_sample(s, u);
      add_count++;
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (!quiet && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result check, sampled mid-cycle while valid and ready are stable
  always @(negedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.mean_sec = mean_sec_o;
      got.mean_usec = mean_usec_o;
      got.least_sec = least_sec_o;
      got.least_usec = least_usec_o;
      got.most_sec = most_sec_o;
      got.most_usec = most_usec_o;
      got.sample_count = sample_count_o;
      if (pending_reports.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: mean %0d.%06d count %0d", got.mean_sec,
                   got.mean_usec, got.sample_count);
      end else begin
        want = pending_reports.pop_front();
        checked_count++;
        if (got != want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d mismatch", checked_count);
            $display("  expected mean %0d.%06d min %0d.%06d max %0d.%06d count %0d",
                     want.mean_sec, want.mean_usec, want.least_sec, want.least_usec,
                     want.most_sec, want.most_usec, want.sample_count);
            $display("  actual   mean %0d.%06d min %0d.%06d max %0d.%06d count %0d",
                     got.mean_sec, got.mean_usec, got.least_sec, got.least_usec,
                     got.most_sec, got.most_usec, got.sample_count);
          end
        end
      end
    end
  end

  // A report with nothing collected yet
  task automatic test_empty_report();
    send_item(OP_REPORT, SEC_MAX, USEC_MAX);
    send_item(OP_REPORT, '0, '0);
  endtask

  // The first sample sets minimum, maximum and total
  task automatic test_first_sample();
    send_item(OP_ADD, 32'd5, 20'd250000);
    send_item(OP_REPORT, '0, '0);
  endtask

  // Field extremes and out-of-range microseconds
  task automatic test_field_extremes();
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, SEC_MAX, USEC_MAX);
    send_item(OP_REPORT, '0, '0);
    send_item(OP_ADD, SEC_MAX, 20'hFFFFF);
    send_item(OP_ADD, 32'd0, USEC_PER_SEC);
    send_item(OP_ADD, 32'hA5A5_5A5A, 20'd1000001);
    send_item(OP_REPORT, SEC_MAX, 20'hFFFFF);
  endtask

  // Microsecond carry at exactly one second, and near-ties on min and max
  task automatic test_usec_carry();
    wait_results_drained();
    send_item(OP_ADD, 32'd7, 20'd500000);
    send_item(OP_ADD, 32'd7, 20'd500000);
    send_item(OP_REPORT, '0, '0);
    send_item(OP_ADD, 32'd0, 20'd1);
    send_item(OP_ADD, SEC_MAX, 20'd999998);
    send_item(OP_REPORT, '0, '0);
  endtask

  // Mixed traffic with changing idle patterns on both sides
  task automatic test_random_traffic();
    op_e                     op;
    logic [FIELD_SEC_W-1:0]  s;
    logic [FIELD_USEC_W-1:0] u;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) wait_results_drained();
      op = ($urandom_range(0, 4) == 0) ? OP_REPORT : OP_ADD;
      case ($urandom_range(0, 7))
        0: s = '0;
        1: s = SEC_MAX;
        2, 3: s = $urandom_range(0, 20);
        4: s = $urandom_range(0, 100000);
        default: s = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0: u = '0;
        1: u = USEC_MAX;
        2: u = FIELD_USEC_W'($urandom_range(1000000, 1048575));
        default: u = FIELD_USEC_W'($urandom_range(0, 999999));
      endcase
      send_item(op, s, u);
    end
  endtask

  // Back-to-back maximal samples with no idling on either side
  task automatic test_max_run();
    wait_results_drained();
    quiet = 1'b1;
    for (int unsigned n = 0; n < MAX_RUN_ADDS; n++) send_item(OP_ADD, SEC_MAX, USEC_MAX);
    send_item(OP_REPORT, '0, '0);
    send_item(OP_ADD, '0, '0);
    send_item(OP_ADD, SEC_MAX, 20'd123456);
    send_item(OP_REPORT, '0, '0);
  endtask

  initial begin
    acc_min_sec = '0;
    acc_min_usec = '0;
    acc_max_sec = '0;
    acc_max_usec = '0;
    acc_total_sec = '0;
    acc_total_usec = '0;
    acc_count = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_report();
    test_first_sample();
    test_field_extremes();
    test_usec_carry();
    test_random_traffic();
    test_max_run();

    // Let the last reports come out and watch for strays
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_reports.size() != 0) error_count++;

    $display("sent %0d samples and %0d reports, %0d results checked, %0d errors",
             add_count, report_count, checked_count, error_count);
    $display("covered empty and first-sample reports, clamped usec, carries, max-value runs");
    if (error_count == 0) begin
      $display("duration_statistics_accumulator_core test passed");
    end else begin
      $display("duration_statistics_accumulator_core test failed");
    end
    $finish;
  end

endmodule
